// ----- hw/rtl/base64_stream_decoder_macros.svh -----
// Assertion helpers shared by the decoder modules.
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define B64D_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define B64D_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/b64d_pkg.sv -----
package b64d_pkg;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_BAD_LEN  = 2'd2
  } status_e;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic [7:0] LOWER_OFFSET = 8'd26;
  localparam logic [7:0] DIGIT_OFFSET = 8'd52;
  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef struct packed {
    logic [7:0] char_in;
    logic       message_end;
  } request_t;

  typedef struct packed {
    logic [7:0] data_byte;
    status_e    status;
    logic       run_end;
    logic       message_done;
  } result_t;

  // One completed group, or one error, handed from the front to the back.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  count;
    status_e     status;
    logic        msg_end;
  } group_t;

  // Bit 6 flags a character of the alphabet; bits 5:0 hold its sextet.
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = {1'b1, 6'(c - CHAR_UPPER_A)};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r = {1'b1, 6'(c - CHAR_LOWER_A + LOWER_OFFSET)};
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      r = {1'b1, 6'(c - CHAR_DIGIT_0 + DIGIT_OFFSET)};
    end else if (c == CHAR_PLUS) begin
      r = {1'b1, SEXTET_PLUS};
    end else if (c == CHAR_SLASH) begin
      r = {1'b1, SEXTET_SLASH};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/base64_stream_decoder.sv -----
// Streaming base64 decoder, standard alphabet with '=' padding.
// Input channel: push_i/full_o carry one character per request with a flag on
// the last character of a message. A request is taken when push_i is high and
// full_o is low. Result channel: while empty_o is low, result_o shows the
// oldest decoded byte or error; it is taken when pop_i is high.
// Every fourth character of a message releases up to three bytes, and a
// message that breaks the rules gives one error result and the rest of it is
// dropped. A result passes the queue, the group register and the output register,
// and further bytes of its group follow one per cycle while pop_i keeps up.
// One character is taken every cycle while full_o is low; the back end drains one
// byte per cycle while pop_i keeps up; the front-to-back queue absorbs 3-byte bursts.
// When the receiver stalls, the output register holds its result, the queue of
// QueueDepth groups fills, and full_o then rises until pop_i frees a slot.
// Reset clears the group state and empties the queue and the output register;
// no setup is needed before the first request.
module base64_stream_decoder #(
  parameter int QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  b64d_pkg::request_t request_i,
  output logic               empty_o,
  input  logic               pop_i,
  output b64d_pkg::result_t  result_o
);

  b64d_pkg::group_t wr_grp;
  b64d_pkg::group_t rd_grp;
  logic             wr_valid;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;

  assign full_o = q_full;

  b64d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .request_i   (request_i),
    .full_i      (q_full),
    .grp_valid_o (wr_valid),
    .grp_o       (wr_grp)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (wr_valid),
    .wr_data_i  (wr_grp),
    .full_o     (q_full),
    .rd_ready_i (q_pop),
    .rd_data_o  (rd_grp),
    .empty_o    (q_empty)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (rd_grp),
    .grp_empty_i (q_empty),
    .grp_pop_o   (q_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .result_o    (result_o)
  );

endmodule

// ----- hw/rtl/b64d_front.sv -----
module b64d_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  b64d_pkg::request_t request_i,
  input  logic               full_i,
  output logic               grp_valid_o,
  output b64d_pkg::group_t   grp_o
);

  logic [17:0] buf_q, buf_d;
  logic [1:0]  pos_q, pos_d;
  logic        third_pad_q, third_pad_d;
  logic        bad_q, bad_d;
  logic        discard_q, discard_d;

  logic       accept;
  logic [6:0] sx;
  logic       is_pad;
  logic [5:0] sval;
  logic       bad;
  logic       msg_end;

  assign accept  = push_i && !full_i;
  assign sx      = b64d_pkg::sextet_of(request_i.char_in);
  assign is_pad  = (request_i.char_in == b64d_pkg::CHAR_PAD);
  assign sval    = sx[6] ? sx[5:0] : 6'd0;
  assign msg_end = request_i.message_end;

  always_comb begin
    buf_d       = buf_q;
    pos_d       = pos_q;
    third_pad_d = third_pad_q;
    bad_d       = bad_q;
    discard_d   = discard_q;
    grp_valid_o = 1'b0;
    grp_o       = '0;
    bad         = bad_q;
    if (accept) begin
      if (discard_q) begin
        if (msg_end) begin
          discard_d = 1'b0;
        end
      end else if (pos_q != 2'd3) begin
        if (msg_end) begin
          buf_d          = '0;
          pos_d          = '0;
          third_pad_d    = 1'b0;
          bad_d          = 1'b0;
          grp_valid_o    = 1'b1;
          grp_o.count    = 2'd1;
          grp_o.status   = b64d_pkg::STATUS_BAD_LEN;
          grp_o.msg_end  = 1'b1;
        end else begin
          if (is_pad) begin
            if (pos_q == 2'd2) begin
              third_pad_d = 1'b1;
            end else begin
              bad_d = 1'b1;
            end
          end else if (!sx[6]) begin
            bad_d = 1'b1;
          end
          buf_d = {buf_q[11:0], sval};
          pos_d = pos_q + 2'd1;
        end
      end else begin
        grp_o.word = {buf_q, sval};
        if (is_pad) begin
          if (!msg_end) begin
            bad = 1'b1;
          end
          grp_o.count = third_pad_q ? 2'd1 : 2'd2;
        end else begin
          if (third_pad_q || !sx[6]) begin
            bad = 1'b1;
          end
          grp_o.count = 2'd3;
        end
        buf_d        = '0;
        pos_d        = '0;
        third_pad_d  = 1'b0;
        bad_d        = 1'b0;
        grp_valid_o  = 1'b1;
        grp_o.status = b64d_pkg::STATUS_OK;
        grp_o.msg_end = msg_end;
        if (bad) begin
          discard_d     = !msg_end;
          grp_o.word    = '0;
          grp_o.count   = 2'd1;
          grp_o.status  = b64d_pkg::STATUS_BAD_CHAR;
          grp_o.msg_end = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      pos_q       <= '0;
      third_pad_q <= 1'b0;
      bad_q       <= 1'b0;
      discard_q   <= 1'b0;
    end else begin
      buf_q       <= buf_d;
      pos_q       <= pos_d;
      third_pad_q <= third_pad_d;
      bad_q       <= bad_d;
      discard_q   <= discard_d;
    end
  end

endmodule

// ----- hw/rtl/b64d_queue.sv -----
`include "base64_stream_decoder_macros.svh"

module b64d_queue #(
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  input  b64d_pkg::group_t wr_data_i,
  output logic             full_o,
  input  logic             rd_ready_i,
  output b64d_pkg::group_t rd_data_o,
  output logic             empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  b64d_pkg::group_t mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          wr_en, rd_en;

  assign full_o    = (count_q == CW'(Depth));
  assign empty_o   = (count_q == '0);
  assign wr_en     = wr_valid_i && !full_o;
  assign rd_en     = rd_ready_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (wr_en && !rd_en) begin
      count_d = count_q + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `B64D_ASSERT_IMP(a_no_write_when_full, wr_valid_i, !full_o, "group written into a full queue")
  `B64D_ASSERT_NXT(a_count_up, wr_en && !rd_en, count_q == $past(count_q) + CW'(1), "count lost")
  `B64D_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(Depth), "queue count beyond depth")

endmodule

// ----- hw/rtl/b64d_back.sv -----
`include "base64_stream_decoder_macros.svh"

module b64d_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b64d_pkg::group_t  grp_i,
  input  logic              grp_empty_i,
  output logic              grp_pop_o,
  input  logic              pop_i,
  output logic              empty_o,
  output b64d_pkg::result_t result_o
);

  b64d_pkg::group_t  cur_q, cur_d;
  logic              cur_valid_q, cur_valid_d;
  logic [1:0]        idx_q, idx_d;
  b64d_pkg::result_t out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic       out_load;
  logic       emit;
  logic       last;
  logic       take;
  logic [7:0] byte_sel;
  logic       out_err;
  logic       err_shape_ok;

  assign out_load  = !out_valid_q || pop_i;
  assign emit      = cur_valid_q && out_load;
  assign last      = (idx_q == cur_q.count - 2'd1);
  assign take      = !grp_empty_i && (!cur_valid_q || (emit && last));
  assign grp_pop_o = take;
  assign empty_o   = !out_valid_q;
  assign result_o  = out_q;

  assign out_err      = out_valid_q && (out_q.status != b64d_pkg::STATUS_OK);
  assign err_shape_ok = (out_q.data_byte == 8'd0) && out_q.run_end && out_q.message_done;

  always_comb begin
    case (idx_q)
      2'd0:    byte_sel = cur_q.word[23:16];
      2'd1:    byte_sel = cur_q.word[15:8];
      default: byte_sel = cur_q.word[7:0];
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = cur_valid_q;
    end
    if (emit) begin
      out_d.data_byte    = byte_sel;
      out_d.status       = cur_q.status;
      out_d.run_end      = last;
      out_d.message_done = last && cur_q.msg_end;
      idx_d              = idx_q + 2'd1;
      if (last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (take) begin
      cur_d       = grp_i;
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  `B64D_ASSERT_IMP(a_error_shape, out_err, err_shape_ok, "malformed error result")
  `B64D_ASSERT_IMP(a_done_is_run_end, out_valid_q && out_q.message_done, out_q.run_end, "message end inside a run")
  `B64D_ASSERT_NXT(a_result_held, out_valid_q && !pop_i, out_valid_q && $stable(out_q), "result changed while stalled")

endmodule
